### sv/lsts_pkg.sv
// shared types and constants for the longest target-sum subarray block
package lsts_pkg;

    localparam int ELEMENT_W = 16;
    localparam int TARGET_W  = 26;
    localparam int LEN_W     = 11;

    typedef struct packed {
        logic signed [ELEMENT_W-1:0] element_value;
        logic                        last_element;
    } t_in_item;

    typedef struct packed {
        logic             match_found;
        logic [LEN_W-1:0] longest_length;
        logic             table_overflow;
        logic             array_done;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_KEY,
        S_SCAN,
        S_UPDATE,
        S_OUT
    } t_state;

endpackage

### sv/longest_subarray_with_target_sum_top.sv
// Longest subarray with a given sum over a stream of elements. Each input item is one signed
// element. The block keeps the running prefix sum and a table of the distinct prefix sums
// seen so far, each with the index of the first element at which it appeared. An element
// passes through S_ADD, S_KEY, S_SCAN, S_UPDATE and S_OUT before the next one can be accepted.
// S_SCAN is a linear scan of the entries in use of the prefix-sum memory, one entry per cycle
// through a single read port, that compares each entry against the old sum and the sought sum.
// Elements beyond MAX_ELEMENTS skip the table and the scan: they set the overflow flag and
// still produce a result. A new item is accepted while a finished result still waits at the
// output. After the last element of an array the per-array state clears; target_sum is
// kept. The table needs no clearing pass after reset.
module longest_subarray_with_target_sum_top
    import lsts_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  t_in_item                   i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_out_item                  o_out_data,
    input  logic                       i_cfg_we,
    input  logic signed [TARGET_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int IDX_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W  = ELEMENT_W + ADDR_W;
    localparam int DIFF_W = ((SUM_W > TARGET_W) ? SUM_W : TARGET_W) + 1;
    localparam int WORD_W = ADDR_W + SUM_W;

    t_state r_state, n_state;

    logic signed [TARGET_W-1:0]  r_target;
    logic signed [SUM_W-1:0]     r_sum;
    logic signed [SUM_W-1:0]     r_new_sum;
    logic signed [DIFF_W-1:0]    r_key;
    logic signed [ELEMENT_W-1:0] r_elem;
    logic                        r_last;
    logic [IDX_W-1:0]            r_idx;
    logic [IDX_W-1:0]            r_used;
    logic [IDX_W-1:0]            r_best;
    logic                        r_any;
    logic                        r_ovf;

    logic [IDX_W-1:0]            r_addr;
    logic                        r_rd_vld;
    logic [WORD_W-1:0]           r_rd_data;
    logic                        r_hit_old;
    logic                        r_hit_key;
    logic [ADDR_W-1:0]           r_hit_pos;

    logic                        r_out_vld;
    t_out_item                   r_out;

    logic [WORD_W-1:0]           mem [MAX_ELEMENTS];

    logic                        in_acc;
    logic                        idx_full;
    logic                        scan_issue;
    logic                        scan_done;
    logic                        out_free;
    logic                        do_insert;
    logic                        do_out;

    logic signed [SUM_W-1:0]     rd_sum;
    logic [ADDR_W-1:0]           rd_pos;
    logic [ADDR_W-1:0]           cur_pos;
    logic                        self_hit;
    logic                        hit;
    logic [ADDR_W-1:0]           hit_pos;
    logic [IDX_W-1:0]            cand_len;

    assign idx_full   = (r_idx >= IDX_W'(MAX_ELEMENTS));
    assign in_acc     = i_in_valid && o_in_ready;
    assign scan_issue = (r_state == S_SCAN) && (r_addr < r_used);
    assign scan_done  = (r_state == S_SCAN) && (r_addr == r_used);
    assign out_free   = !r_out_vld || i_out_ready;

    assign rd_sum   = r_rd_data[SUM_W-1:0];
    assign rd_pos   = r_rd_data[WORD_W-1:SUM_W];
    assign cur_pos  = r_idx[ADDR_W-1:0];
    assign self_hit = !r_hit_old && (DIFF_W'(r_sum) == r_key);
    assign hit      = r_hit_key || self_hit;
    assign hit_pos  = r_hit_key ? r_hit_pos : cur_pos;
    assign cand_len = IDX_W'(cur_pos) - IDX_W'(hit_pos) + IDX_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = idx_full ? S_OUT : S_ADD;
                end
            end
            S_ADD:    n_state = S_KEY;
            S_KEY:    n_state = S_SCAN;
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        do_insert  = 1'b0;
        do_out     = 1'b0;
        unique case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_UPDATE: do_insert  = !r_hit_old;
            S_OUT:    do_out     = out_free;
            default: begin
            end
        endcase
    end

    // prefix-sum table
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            mem[r_used[ADDR_W-1:0]] <= {cur_pos, r_sum};
        end
        if (scan_issue) begin
            r_rd_data <= mem[r_addr[ADDR_W-1:0]];
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_elem <= i_in_data.element_value;
            r_last <= i_in_data.last_element;
        end
        if (r_state == S_ADD) begin
            r_new_sum <= r_sum + SUM_W'(r_elem);
        end
        if (r_state == S_KEY) begin
            r_key <= DIFF_W'(r_new_sum) - DIFF_W'(r_target);
        end
        if (r_rd_vld && (DIFF_W'(rd_sum) == r_key)) begin
            r_hit_pos <= rd_pos;
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_target  <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
            r_used    <= '0;
            r_best    <= '0;
            r_any     <= 1'b0;
            r_ovf     <= 1'b0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_hit_old <= 1'b0;
            r_hit_key <= 1'b0;
            r_out_vld <= 1'b0;
            r_out     <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= scan_issue;

            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end

            if (in_acc && idx_full) begin
                r_ovf <= 1'b1;
            end

            if (r_state == S_KEY) begin
                r_addr    <= '0;
                r_hit_old <= 1'b0;
                r_hit_key <= 1'b0;
            end

            if (scan_issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end

            if (r_rd_vld) begin
                if (rd_sum == r_sum) begin
                    r_hit_old <= 1'b1;
                end
                if (DIFF_W'(rd_sum) == r_key) begin
                    r_hit_key <= 1'b1;
                end
            end

            if (r_state == S_UPDATE) begin
                if (do_insert) begin
                    r_used <= r_used + IDX_W'(1);
                end
                if (hit) begin
                    r_any <= 1'b1;
                    if (cand_len > r_best) begin
                        r_best <= cand_len;
                    end
                end
                r_sum <= r_new_sum;
                r_idx <= r_idx + IDX_W'(1);
            end

            if (do_out) begin
                r_out_vld            <= 1'b1;
                r_out.match_found    <= r_any;
                r_out.longest_length <= LEN_W'(r_best);
                r_out.table_overflow <= r_ovf;
                r_out.array_done     <= r_last;
                if (r_last) begin
                    r_sum  <= '0;
                    r_idx  <= '0;
                    r_used <= '0;
                    r_best <= '0;
                    r_any  <= 1'b0;
                    r_ovf  <= 1'b0;
                end
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
